[sv/slbc_pkg.sv]
// shared types, constants and the color table for the status led blink controller
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package slbc_pkg;

  localparam int TICK_COUNT_BITS_DEF = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_SHIFT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_HALF = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_HALF = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_HALF = 2'd3;

  // input kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD = 1'b1;

  // light modes
  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_ON = 3'd1;
  localparam logic [2:0] MODE_BLINK4 = 3'd2;
  localparam logic [2:0] MODE_BLINK2 = 3'd3;
  localparam logic [2:0] MODE_BLINK1 = 3'd4;

  localparam logic [3:0] COLOR_BLACK = 4'd0;

  // reset values of the registers
  localparam logic [2:0] DIM_SHIFT_RST = 3'd2;
  localparam logic [15:0] FAST_HALF_RST = 16'd125;
  localparam logic [15:0] MEDIUM_HALF_RST = 16'd250;
  localparam logic [15:0] SLOW_HALF_RST = 16'd500;

  typedef struct packed {
    logic       kind;
    logic [2:0] mode;
    logic [3:0] color;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lit;
  } out_t;

  typedef struct packed {
    logic [2:0]  dim_shift;
    logic [15:0] fast_half_period;
    logic [15:0] medium_half_period;
    logic [15:0] slow_half_period;
  } cfg_t;

  // light state after the current transfer, handed to the color stage
  typedef struct packed {
    logic       lit;
    logic [3:0] color;
  } light_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t color_rgb(input logic [3:0] c);
    rgb_t v;
    case (c)
      4'd1:    v = '{8'h00, 8'h00, 8'hFF};
      4'd2:    v = '{8'h00, 8'hFF, 8'hFF};
      4'd3:    v = '{8'h00, 8'hFF, 8'h00};
      4'd4:    v = '{8'hFF, 8'h00, 8'hFF};
      4'd5:    v = '{8'hFF, 8'h70, 8'h00};
      4'd6:    v = '{8'h80, 8'h00, 8'hFF};
      4'd7:    v = '{8'hFF, 8'h00, 8'h00};
      4'd8:    v = '{8'h80, 8'h80, 8'h80};
      4'd9:    v = '{8'hFF, 8'hFF, 8'h00};
      default: v = '{8'h00, 8'h00, 8'h00};
    endcase
    return v;
  endfunction

endpackage

[sv/slbc_regs.sv]
// configuration registers: dim shift and the three blink half periods
// depends on slbc_pkg
`timescale 1ns / 1ps

module slbc_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [slbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output slbc_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_shift <= slbc_pkg::DIM_SHIFT_RST;
      cfg.fast_half_period <= slbc_pkg::FAST_HALF_RST;
      cfg.medium_half_period <= slbc_pkg::MEDIUM_HALF_RST;
      cfg.slow_half_period <= slbc_pkg::SLOW_HALF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slbc_pkg::REG_DIM_SHIFT:   cfg.dim_shift <= cfg_data[2:0];
        slbc_pkg::REG_FAST_HALF:   cfg.fast_half_period <= cfg_data;
        slbc_pkg::REG_MEDIUM_HALF: cfg.medium_half_period <= cfg_data;
        slbc_pkg::REG_SLOW_HALF:   cfg.slow_half_period <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/slbc_core.sv]
// mode stack, blink toggle and tick counter; gives the light state after each transfer
// depends on slbc_pkg
`timescale 1ns / 1ps

module slbc_core #(
  parameter int TICK_COUNT_BITS = slbc_pkg::TICK_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  slbc_pkg::in_t       item,
  input  slbc_pkg::cfg_t      cfg,
  output slbc_pkg::light_t    light_next
);

  localparam int INC_W = TICK_COUNT_BITS + 1;
  localparam int CMP_W = (INC_W > 16) ? INC_W : 16;

  logic [2:0]                 cur_mode, cur_mode_next;
  logic [3:0]                 cur_color, cur_color_next;
  logic [2:0]                 saved_mode, saved_mode_next;
  logic [3:0]                 saved_color, saved_color_next;
  logic                       light_on, light_on_next;
  logic [TICK_COUNT_BITS-1:0] elapsed, elapsed_next;

  logic [INC_W-1:0] cnt_inc;
  logic [15:0]      half;
  logic             is_blink;
  logic             period_hit;

  always_comb begin
    cnt_inc = {1'b0, elapsed} + INC_W'(1);
    case (cur_mode)
      slbc_pkg::MODE_BLINK4: half = cfg.fast_half_period;
      slbc_pkg::MODE_BLINK2: half = cfg.medium_half_period;
      default:               half = cfg.slow_half_period;
    endcase
    is_blink = (cur_mode >= slbc_pkg::MODE_BLINK4) && (cur_mode <= slbc_pkg::MODE_BLINK1);
    // a carry out of the counter means it saturated
    period_hit = (CMP_W'(cnt_inc) >= CMP_W'(half)) || cnt_inc[TICK_COUNT_BITS];

    cur_mode_next = cur_mode;
    cur_color_next = cur_color;
    saved_mode_next = saved_mode;
    saved_color_next = saved_color;
    light_on_next = light_on;
    elapsed_next = elapsed;

    if (accept) begin
      if (item.kind == slbc_pkg::KIND_CMD) begin
        if (item.mode <= slbc_pkg::MODE_BLINK1) begin
          if (item.mode != slbc_pkg::MODE_OFF) begin
            saved_mode_next = cur_mode;
            saved_color_next = cur_color;
            cur_mode_next = item.mode;
            cur_color_next = item.color;
          end else begin
            cur_mode_next = saved_mode;
            cur_color_next = saved_color;
            saved_mode_next = slbc_pkg::MODE_OFF;
            saved_color_next = slbc_pkg::COLOR_BLACK;
          end
          elapsed_next = '0;
          // one blink step under the new mode
          if (cur_mode_next == slbc_pkg::MODE_OFF) begin
            light_on_next = 1'b0;
          end else if (cur_mode_next == slbc_pkg::MODE_ON) begin
            light_on_next = 1'b1;
          end else begin
            light_on_next = !light_on;
          end
        end
      end else if (is_blink) begin
        if (period_hit) begin
          light_on_next = !light_on;
          elapsed_next = '0;
        end else begin
          elapsed_next = cnt_inc[TICK_COUNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= slbc_pkg::MODE_OFF;
      cur_color <= slbc_pkg::COLOR_BLACK;
      saved_mode <= slbc_pkg::MODE_OFF;
      saved_color <= slbc_pkg::COLOR_BLACK;
      light_on <= 1'b0;
      elapsed <= '0;
    end else begin
      cur_mode <= cur_mode_next;
      cur_color <= cur_color_next;
      saved_mode <= saved_mode_next;
      saved_color <= saved_color_next;
      light_on <= light_on_next;
      elapsed <= elapsed_next;
    end
  end

  assign light_next.lit = light_on_next;
  assign light_next.color = cur_color_next;

endmodule

[sv/slbc_color.sv]
// color lookup and dimming: turns the light state into drive levels
// depends on slbc_pkg
`timescale 1ns / 1ps

module slbc_color (
  input  slbc_pkg::light_t light,
  input  logic [2:0]       dim_shift,
  output slbc_pkg::out_t   result
);

  slbc_pkg::rgb_t rgb;

  always_comb begin
    rgb = slbc_pkg::color_rgb(light.color);
    if (light.lit) begin
      result.red = rgb.r >> dim_shift;
      result.green = rgb.g >> dim_shift;
      result.blue = rgb.b >> dim_shift;
    end else begin
      result.red = '0;
      result.green = '0;
      result.blue = '0;
    end
    result.lit = light.lit;
  end

endmodule

[sv/status_led_blink_controller.sv]
// status led blink controller: one result per transfer, output valid in the cycle after the
// input transfer; throughput one item per cycle while the receiver takes results, the output register frees
// whenever its result is taken in the same cycle
// reset (synchronous, active high) clears mode, saved pair, light and tick count,
// loads the register defaults and empties the output register
// depends on slbc_pkg, slbc_regs, slbc_core, slbc_color
`timescale 1ns / 1ps

module status_led_blink_controller #(
  parameter int TICK_COUNT_BITS = slbc_pkg::TICK_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  slbc_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output slbc_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [slbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slbc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  slbc_pkg::cfg_t   cfg;
  slbc_pkg::light_t light_next;
  slbc_pkg::out_t   result;
  logic             accept;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;

  slbc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slbc_core #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (in_data),
    .cfg        (cfg),
    .light_next (light_next)
  );

  slbc_color u_color (
    .light     (light_next),
    .dim_shift (cfg.dim_shift),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

[sv/slbc_checker.sv]
// port-level checks for the status led blink controller, bound to the top level
// depends on slbc_pkg
`timescale 1ns / 1ps

module slbc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input slbc_pkg::out_t                     out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every input transfer shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer gave no result");

  // an empty output register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

  // a dark light drives nothing
  a_dark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.lit |->
      out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("dark light with nonzero drive");

endmodule

bind status_led_blink_controller slbc_checker u_slbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/tb_top.sv]
// self-checking testbench for status_led_blink_controller: a light tracker follows mode,
// saved pair, blink count and registers and checks every output transfer in order
// depends on slbc_pkg
`timescale 1ns / 1ps

localparam logic [3:0] COLOR_BLUE = 4'd1;
localparam logic [3:0] COLOR_CYAN = 4'd2;
localparam logic [3:0] COLOR_GREEN = 4'd3;
localparam logic [3:0] COLOR_MAGENTA = 4'd4;
localparam logic [3:0] COLOR_ORANGE = 4'd5;
localparam logic [3:0] COLOR_PURPLE = 4'd6;
localparam logic [3:0] COLOR_RED = 4'd7;
localparam logic [3:0] COLOR_WHITE = 4'd8;
localparam logic [3:0] COLOR_YELLOW = 4'd9;
localparam logic [3:0] COLOR_UNDEF = 4'd15;
localparam logic [2:0] MODE_UNUSED_LO = slbc_pkg::MODE_BLINK1 + 3'd1;
localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
localparam int TICKS_W = slbc_pkg::TICK_COUNT_BITS_DEF;

class blink_tracker;
  logic [2:0] dim;
  logic [15:0] half_fast, half_medium, half_slow;
  logic [2:0] mode_now, mode_saved;
  logic [3:0] color_now, color_saved;
  logic light;
  logic [TICKS_W-1:0] ticks;
  slbc_pkg::out_t expected_levels[$];
  int errors;

  function new();
    dim = slbc_pkg::DIM_SHIFT_RST;
    half_fast = slbc_pkg::FAST_HALF_RST;
    half_medium = slbc_pkg::MEDIUM_HALF_RST;
    half_slow = slbc_pkg::SLOW_HALF_RST;
    mode_now = slbc_pkg::MODE_OFF;
    mode_saved = slbc_pkg::MODE_OFF;
    color_now = slbc_pkg::COLOR_BLACK;
    color_saved = slbc_pkg::COLOR_BLACK;
    light = 1'b0;
    ticks = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [slbc_pkg::CFG_INDEX_W-1:0] idx,
                        logic [slbc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      slbc_pkg::REG_DIM_SHIFT: dim = val[2:0];
      slbc_pkg::REG_FAST_HALF: half_fast = val;
      slbc_pkg::REG_MEDIUM_HALF: half_medium = val;
      default: half_slow = val;
    endcase
  endfunction

  function logic [23:0] palette(logic [3:0] c);
    case (c)
      COLOR_BLUE:    return 24'h0000FF;
      COLOR_CYAN:    return 24'h00FFFF;
      COLOR_GREEN:   return 24'h00FF00;
      COLOR_MAGENTA: return 24'hFF00FF;
      COLOR_ORANGE:  return 24'hFF7000;
      COLOR_PURPLE:  return 24'h8000FF;
      COLOR_RED:     return 24'hFF0000;
      COLOR_WHITE:   return 24'h808080;
      COLOR_YELLOW:  return 24'hFFFF00;
      default:       return 24'h000000;
    endcase
  endfunction

  function logic [15:0] half_for(logic [2:0] m);
    if (m == slbc_pkg::MODE_BLINK4) return half_fast;
    if (m == slbc_pkg::MODE_BLINK2) return half_medium;
    return half_slow;
  endfunction

  function void take_item(slbc_pkg::in_t it);
    logic [TICKS_W:0] count_next;
    logic [23:0] rgb;
    slbc_pkg::out_t lvl;
    if (it.kind == slbc_pkg::KIND_CMD) begin
      // unused modes leave everything as it was
      if (it.mode <= slbc_pkg::MODE_BLINK1) begin
        if (it.mode != slbc_pkg::MODE_OFF) begin
          mode_saved = mode_now;
          color_saved = color_now;
          mode_now = it.mode;
          color_now = it.color;
        end else begin
          mode_now = mode_saved;
          color_now = color_saved;
          mode_saved = slbc_pkg::MODE_OFF;
          color_saved = slbc_pkg::COLOR_BLACK;
        end
        ticks = '0;
        if (mode_now == slbc_pkg::MODE_OFF) light = 1'b0;
        else if (mode_now == slbc_pkg::MODE_ON) light = 1'b1;
        else light = !light;
      end
    end else if (mode_now >= slbc_pkg::MODE_BLINK4 && mode_now <= slbc_pkg::MODE_BLINK1) begin
      count_next = {1'b0, ticks} + (TICKS_W+1)'(1);
      // a zero half period toggles on every tick, the count saturates at its width
      if (count_next >= {1'b0, half_for(mode_now)} ||
          count_next > {1'b0, {TICKS_W{1'b1}}}) begin
        light = !light;
        ticks = '0;
      end else begin
        ticks = count_next[TICKS_W-1:0];
      end
    end
    rgb = light ? palette(color_now) : 24'h0;
    lvl.red = rgb[23:16] >> dim;
    lvl.green = rgb[15:8] >> dim;
    lvl.blue = rgb[7:0] >> dim;
    lvl.lit = light;
    expected_levels.push_back(lvl);
  endfunction

  function void report(string field, int unsigned want, int unsigned got);
    errors++;
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endfunction

  function void check_level(slbc_pkg::out_t got);
    slbc_pkg::out_t want;
    if (expected_levels.size() == 0) begin
      report("unexpected transfer", 0, 32'(got));
      return;
    end
    want = expected_levels.pop_front();
    if (got.red !== want.red) report("red", 32'(want.red), 32'(got.red));
    if (got.green !== want.green) report("green", 32'(want.green), 32'(got.green));
    if (got.blue !== want.blue) report("blue", 32'(want.blue), 32'(got.blue));
    if (got.lit !== want.lit) report("lit", 32'(want.lit), 32'(got.lit));
  endfunction
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  slbc_pkg::in_t in_data;
  slbc_pkg::out_t out_data;
  logic cfg_we;
  logic [slbc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [slbc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic quiet;

  blink_tracker light_track = new();

  status_led_blink_controller dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic slbc_pkg::in_t make_item(logic kind, logic [2:0] mode,
                                              logic [3:0] color);
    slbc_pkg::in_t it;
    it.kind = kind;
    it.mode = mode;
    it.color = color;
    return it;
  endfunction

  task automatic send_item(input slbc_pkg::in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (light_track.expected_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slbc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [slbc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    light_track.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) light_track.check_level(out_data);
      if (in_valid && in_ready) light_track.take_item(in_data);
    end
  end

  // receiver stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    #4000000;
    $display("status_led_blink_controller: mismatch");
    $finish;
  end

  initial begin
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, default registers: push, pop, double pop, unused mode, unknown color
    send_item(make_item(slbc_pkg::KIND_TICK, MODE_UNUSED_HI, COLOR_UNDEF));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_ON, COLOR_RED));
    send_item(make_item(slbc_pkg::KIND_TICK, slbc_pkg::MODE_OFF, slbc_pkg::COLOR_BLACK));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_BLINK4, COLOR_WHITE));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_OFF, COLOR_GREEN));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_OFF, slbc_pkg::COLOR_BLACK));
    send_item(make_item(slbc_pkg::KIND_CMD, MODE_UNUSED_HI, COLOR_UNDEF));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_ON, COLOR_UNDEF));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_BLINK2, COLOR_YELLOW));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_BLINK1, COLOR_ORANGE));
    send_item(make_item(slbc_pkg::KIND_CMD, MODE_UNUSED_LO, COLOR_BLUE));
    send_item(make_item(slbc_pkg::KIND_TICK, slbc_pkg::MODE_BLINK1, COLOR_CYAN));
    drain();

    // zero half period, full brightness, the longest period
    write_reg(slbc_pkg::REG_DIM_SHIFT, 16'd0);
    write_reg(slbc_pkg::REG_FAST_HALF, 16'd0);
    write_reg(slbc_pkg::REG_MEDIUM_HALF, 16'd1);
    write_reg(slbc_pkg::REG_SLOW_HALF, 16'hFFFF);
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_BLINK4, COLOR_BLUE));
    repeat (3)
      send_item(make_item(slbc_pkg::KIND_TICK, slbc_pkg::MODE_OFF, slbc_pkg::COLOR_BLACK));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_BLINK2, COLOR_MAGENTA));
    repeat (2)
      send_item(make_item(slbc_pkg::KIND_TICK, slbc_pkg::MODE_OFF, slbc_pkg::COLOR_BLACK));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_BLINK1, COLOR_PURPLE));
    repeat (2)
      send_item(make_item(slbc_pkg::KIND_TICK, slbc_pkg::MODE_OFF, slbc_pkg::COLOR_BLACK));
    send_item(make_item(slbc_pkg::KIND_CMD, slbc_pkg::MODE_OFF, COLOR_CYAN));
    drain();

    for (int p = 0; p < 8; p++) begin
      quiet = (p == 3);
      case (p)
        1: write_reg(slbc_pkg::REG_DIM_SHIFT, {13'($urandom), 3'd7});
        2: write_reg(slbc_pkg::REG_DIM_SHIFT, {13'($urandom), 3'd0});
        default: write_reg(slbc_pkg::REG_DIM_SHIFT, 16'($urandom));
      endcase
      if (p == 5) begin
        write_reg(slbc_pkg::REG_FAST_HALF, 16'd1);
        write_reg(slbc_pkg::REG_MEDIUM_HALF, 16'hFFFF);
        write_reg(slbc_pkg::REG_SLOW_HALF, 16'($urandom_range(2, 5)));
      end else if (p == 6) begin
        write_reg(slbc_pkg::REG_FAST_HALF, 16'($urandom_range(0, 40)));
        write_reg(slbc_pkg::REG_MEDIUM_HALF, 16'($urandom_range(0, 40)));
        write_reg(slbc_pkg::REG_SLOW_HALF, 16'($urandom_range(0, 40)));
      end else begin
        write_reg(slbc_pkg::REG_FAST_HALF, 16'($urandom_range(0, 6)));
        write_reg(slbc_pkg::REG_MEDIUM_HALF, 16'($urandom_range(0, 6)));
        write_reg(slbc_pkg::REG_SLOW_HALF, 16'($urandom_range(0, 8)));
      end
      // mostly ticks and well-formed commands, some with unused modes or colors
      repeat (140) begin
        r = $urandom_range(0, 99);
        if (r < 62)
          send_item(make_item(slbc_pkg::KIND_TICK, 3'($urandom), 4'($urandom)));
        else if (r < 90)
          send_item(make_item(slbc_pkg::KIND_CMD,
                              3'($urandom_range(slbc_pkg::MODE_OFF, slbc_pkg::MODE_BLINK1)),
                              4'($urandom_range(slbc_pkg::COLOR_BLACK, COLOR_YELLOW))));
        else
          send_item(make_item(slbc_pkg::KIND_CMD, 3'($urandom), 4'($urandom)));
      end
      drain();
    end
    quiet = 1'b0;

    repeat (4) @(posedge clk);
    if (light_track.errors == 0 && light_track.expected_levels.size() == 0)
      $display("status_led_blink_controller: match");
    else
      $display("status_led_blink_controller: mismatch");
    $finish;
  end
endmodule

[files.f]
sv/slbc_pkg.sv
sv/slbc_regs.sv
sv/slbc_core.sv
sv/slbc_color.sv
sv/status_led_blink_controller.sv
sv/slbc_checker.sv
verif/tb_top.sv
